// ===== design/sbp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbp_pkg: shared types, constants and functions for the screen blend pixel
// Channel format, stage count, register indexes and the unit-scale divide.
// ---------------------------------------------------------------------------
package sbp_pkg;

  // Channel code width; the all-ones code means 1.0
  localparam int CH_BITS  = 16;
  localparam int PROD_BITS = 2 * CH_BITS;

  localparam logic [CH_BITS-1:0]   CH_ONE  = {CH_BITS{1'b1}};
  localparam logic [PROD_BITS-1:0] CH_HALF = PROD_BITS'(CH_ONE >> 1);

  // Pipeline stages ahead of the output register
  localparam int NUM_STAGES = 6;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OPACITY     = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASK_ENABLE = 1'd1;

  typedef logic [CH_BITS-1:0]    chan_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    chan_t opacity;
    logic  mask_enable;
  } cfg_t;

  // floor(x / ONE) for x below ONE*ONE + ONE. With x = q0*2^N + lo the
  // remainder against q0 is lo + q0, which stays below 2*ONE, so a single
  // compare fixes the quotient.
  function automatic chan_t div_one(input prod_t x);
    chan_t              q0;
    logic [CH_BITS:0]   rem;
    q0  = x[PROD_BITS-1:CH_BITS];
    rem = {1'b0, x[CH_BITS-1:0]} + {1'b0, q0};
    if (rem >= {1'b0, CH_ONE}) begin
      div_one = q0 + chan_t'(1);
    end else begin
      div_one = q0;
    end
  endfunction

  // Round-to-nearest reduction of a product of two channel codes
  function automatic chan_t round_one(input prod_t p);
    round_one = div_one(p + CH_HALF);
  endfunction

endpackage

// ===== design/screen_blend_pixel.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// screen_blend_pixel: screen blend with layer opacity and optional mask
// Three color lanes and an alpha path feed a shared output register.
// ---------------------------------------------------------------------------
// Takes one pixel per cycle while the output is not stalled and returns its
// blended result through six pipeline stages and then the output register.
// The depth is set by the two multiply-and-round steps of the alpha path
// that must finish before the color lanes can mix. Each stage advances on
// its own, so empty stages fill while a result waits at the output; a
// stall reaches the input only when every stage holds a pixel. The user must
// write opacity (index 0) and mask_enable (index 1) through cfg_write only
// while no pixel is in flight; the block itself does not enforce this.
module screen_blend_pixel (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [sbp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  sbp_pkg::chan_t                    cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sbp_pkg::chan_t                    base_red,
  input  sbp_pkg::chan_t                    base_green,
  input  sbp_pkg::chan_t                    base_blue,
  input  sbp_pkg::chan_t                    base_alpha,
  input  sbp_pkg::chan_t                    layer_red,
  input  sbp_pkg::chan_t                    layer_green,
  input  sbp_pkg::chan_t                    layer_blue,
  input  sbp_pkg::chan_t                    layer_alpha,
  input  sbp_pkg::chan_t                    mask_value,
  input  logic                              last_pixel,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output sbp_pkg::chan_t                    out_red,
  output sbp_pkg::chan_t                    out_green,
  output sbp_pkg::chan_t                    out_blue,
  output sbp_pkg::chan_t                    out_alpha,
  output logic                              last_pixel_out
);
  import sbp_pkg::*;

  cfg_t                cfg;
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES:0]   stage_rdy;
  stage_en_t           stage_en;
  chan_t               alpha;
  chan_t               mix_red;
  chan_t               mix_green;
  chan_t               mix_blue;
  chan_t               side_alpha [NUM_STAGES];
  logic                side_last  [NUM_STAGES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.opacity     <= CH_ONE;
      cfg.mask_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OPACITY:     cfg.opacity     <= cfg_data;
        REG_MASK_ENABLE: cfg.mask_enable <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // per-stage advance: a stage loads when empty or when its successor moves
  always_comb begin
    stage_rdy[NUM_STAGES] = !out_valid || !out_stall;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      stage_rdy[i] = !stage_valid[i] || stage_rdy[i+1];
    end
  end

  assign stage_en = stage_rdy[NUM_STAGES-1:0];
  assign in_stall = !stage_rdy[0];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stage_en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // base alpha and run marker ride alongside
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      side_alpha[0] <= base_alpha;
      side_last[0]  <= last_pixel;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (stage_en[i]) begin
        side_alpha[i] <= side_alpha[i-1];
        side_last[i]  <= side_last[i-1];
      end
    end
  end

  sbp_alpha u_alpha (
    .clk         (clk),
    .stage_en    (stage_en),
    .cfg         (cfg),
    .layer_alpha (layer_alpha),
    .mask_value  (mask_value),
    .alpha       (alpha)
  );

  sbp_lane u_lane_red (
    .clk      (clk),
    .stage_en (stage_en),
    .base     (base_red),
    .layer    (layer_red),
    .alpha    (alpha),
    .mix      (mix_red)
  );

  sbp_lane u_lane_green (
    .clk      (clk),
    .stage_en (stage_en),
    .base     (base_green),
    .layer    (layer_green),
    .alpha    (alpha),
    .mix      (mix_green)
  );

  sbp_lane u_lane_blue (
    .clk      (clk),
    .stage_en (stage_en),
    .base     (base_blue),
    .layer    (layer_blue),
    .alpha    (alpha),
    .mix      (mix_blue)
  );

  // output register: merges the lanes with the sideband
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_rdy[NUM_STAGES]) begin
      out_valid <= stage_valid[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[NUM_STAGES]) begin
      out_red        <= mix_red;
      out_green      <= mix_green;
      out_blue       <= mix_blue;
      out_alpha      <= side_alpha[NUM_STAGES-1];
      last_pixel_out <= side_last[NUM_STAGES-1];
    end
  end

  // input is held off only while the first stage is occupied
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid[0])
    else $error("input stalled with an empty first stage");

  // a new result only comes from a full last stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid[NUM_STAGES-1]))
    else $error("result appeared without a pixel in the last stage");

  // a finished pixel moves into an empty output register
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid[NUM_STAGES-1] && !out_valid) |=> out_valid)
    else $error("finished pixel did not reach the output register");

endmodule

// ===== design/sbp_alpha.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbp_alpha: effective alpha path
// layer_alpha * opacity, optionally * mask, each product rounded; result is
// ready at the fourth stage register for the color lanes.
// ---------------------------------------------------------------------------
module sbp_alpha (
  input  logic               clk,
  input  sbp_pkg::stage_en_t stage_en,
  input  sbp_pkg::cfg_t      cfg,
  input  sbp_pkg::chan_t     layer_alpha,
  input  sbp_pkg::chan_t     mask_value,
  output sbp_pkg::chan_t     alpha
);
  import sbp_pkg::*;

  prod_t alpha_prod1;
  chan_t mask1;
  chan_t alpha2;
  chan_t mask2;
  prod_t mask_prod3;
  chan_t alpha3;
  chan_t alpha4;

  // stage 1: layer alpha times opacity
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      alpha_prod1 <= prod_t'(layer_alpha) * prod_t'(cfg.opacity);
      mask1       <= mask_value;
    end
  end

  // stage 2: round the opacity product
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      alpha2 <= round_one(alpha_prod1);
      mask2  <= mask1;
    end
  end

  // stage 3: mask product
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      mask_prod3 <= prod_t'(alpha2) * prod_t'(mask2);
      alpha3     <= alpha2;
    end
  end

  // stage 4: pick masked or plain alpha
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      if (cfg.mask_enable) begin
        alpha4 <= round_one(mask_prod3);
      end else begin
        alpha4 <= alpha3;
      end
    end
  end

  assign alpha = alpha4;

endmodule

// ===== design/sbp_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbp_lane: one color channel
// Screen of base and layer, then mix with the base by the effective alpha.
// ---------------------------------------------------------------------------
module sbp_lane (
  input  logic               clk,
  input  sbp_pkg::stage_en_t stage_en,
  input  sbp_pkg::chan_t     base,
  input  sbp_pkg::chan_t     layer,
  input  sbp_pkg::chan_t     alpha,
  output sbp_pkg::chan_t     mix
);
  import sbp_pkg::*;

  prod_t inv_prod1;
  chan_t base1;
  chan_t screen2;
  chan_t base2;
  chan_t screen3;
  chan_t base3;
  chan_t screen4;
  chan_t base4;
  prod_t screen_prod5;
  prod_t base_prod5;
  prod_t sum6;

  // stage 1: (1-base)(1-layer)
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      inv_prod1 <= prod_t'(CH_ONE - base) * prod_t'(CH_ONE - layer);
      base1     <= base;
    end
  end

  // stage 2: screen value
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      screen2 <= CH_ONE - round_one(inv_prod1);
      base2   <= base1;
    end
  end

  // stages 3 and 4: wait for the alpha path
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      screen3 <= screen2;
      base3   <= base2;
    end
    if (stage_en[3]) begin
      screen4 <= screen3;
      base4   <= base3;
    end
  end

  // stage 5: weighted terms
  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      screen_prod5 <= prod_t'(screen4) * prod_t'(alpha);
      base_prod5   <= prod_t'(base4) * prod_t'(CH_ONE - alpha);
    end
  end

  // stage 6: sum with rounding offset; cannot exceed ONE*ONE + HALF
  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      sum6 <= screen_prod5 + base_prod5 + CH_HALF;
    end
  end

  // zero alpha gives base*ONE + HALF here, which divides back to the base
  assign mix = div_one(sum6);

endmodule
